// File: hw/rtl/rgb_color_difference_mask_macros.svh
// Assertion macros for the checker file of the color difference mask.
`ifndef RGB_COLOR_DIFFERENCE_MASK_MACROS_SVH
`define RGB_COLOR_DIFFERENCE_MASK_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RCDM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rcdm: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RCDM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rcdm: next-cycle check failed");

// Next-cycle implication that stays active through reset.
`define RCDM_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("rcdm: reset check failed");

`endif

// File: hw/rtl/rcdm_pkg.sv
// Package with the types and constants of the color difference mask.
`timescale 1ns / 1ps
`default_nettype none

package rcdm_pkg;

    // Number of register stages from the input to the output register.
    localparam int STAGES = 6;

    // Configuration register indexes.
    localparam logic CFG_KEY_MODE = 1'b0;
    localparam logic CFG_GAIN     = 1'b1;

    // Key modes.
    localparam logic [2:0] MODE_RED     = 3'd0;
    localparam logic [2:0] MODE_GREEN   = 3'd1;
    localparam logic [2:0] MODE_BLUE    = 3'd2;
    localparam logic [2:0] MODE_CYAN    = 3'd3;
    localparam logic [2:0] MODE_MAGENTA = 3'd4;
    localparam logic [2:0] MODE_YELLOW  = 3'd5;
    localparam logic [2:0] MODE_MAX     = 3'd6;
    localparam logic [2:0] MODE_UNUSED  = 3'd7;

    // Reset values of the configuration registers.
    localparam logic [2:0]  KEY_MODE_RESET = MODE_RED;
    localparam logic [15:0] GAIN_RESET     = 16'd1000;

    // Rounding offset of the premultiply.
    localparam logic [15:0] PREMUL_ROUND = 16'd127;

    // Gain scaling: round by half of one thousand, saturate at 255.5 thousandths.
    localparam logic [23:0] GAIN_ROUND = 24'd500;
    localparam logic [23:0] SAT_LIMIT  = 24'd256000;

    // Division by 125 as multiply by ceil(2^22 / 125) and shift by 22;
    // exact for dividends below 59074.
    localparam logic [15:0] RECIP_125   = 16'd33555;
    localparam int          RECIP_SHIFT = 22;

    localparam logic [7:0] CHAN_MAX = 8'd255;

    // Per-lane control from the top level.
    typedef struct packed {
        logic en_mul;
        logic en_div;
        logic invert;
    } t_lane_ctrl;

endpackage

`default_nettype wire

// File: hw/rtl/rcdm_lane.sv
// One color channel lane: optional inversion and premultiply by alpha / 255.
`timescale 1ns / 1ps
`default_nettype none

module rcdm_lane (
    input  wire logic              i_clk,
    input  wire rcdm_pkg::t_lane_ctrl i_ctrl,
    input  wire logic [7:0]        i_alpha,
    input  wire logic [7:0]        i_chan,
    output logic [7:0]             o_chan
);

    logic [7:0]  chan_k;
    logic [15:0] r_prod;
    logic [16:0] div_sum;

    // Inversion is 255 minus the value, which for eight bits is the complement.
    assign chan_k = i_ctrl.invert ? ~i_chan : i_chan;

    // First stage: channel times alpha plus the rounding offset.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_mul) begin
            r_prod <= ({8'd0, chan_k} * {8'd0, i_alpha}) + rcdm_pkg::PREMUL_ROUND;
        end
    end

    // Division by 255 as (x + 1 + x / 256) / 256, exact for x below 65535.
    // An opaque pixel gives back the channel itself, so no bypass is needed.
    assign div_sum = {1'b0, r_prod} + 17'd1 + {9'd0, r_prod[15:8]};

    // Second stage: the premultiplied channel.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_div) begin
            o_chan <= div_sum[15:8];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/rgb_color_difference_mask.sv
// Top level of the color difference key mask pipeline.
//
// Usage: one ARGB pixel enters per request on the input channel
// (i_in_valid / o_in_ready) and one mask alpha leaves per request on the
// output channel (o_out_valid / i_out_ready). The mask color is implied white.
// Configuration is written through i_cfg_wr_en, i_cfg_index and i_cfg_data
// while no pixel is in flight: index 0 is the key mode, index 1 the gain in
// thousandths.
// Throughput is one pixel per clock when the receiver takes every result;
// that rate comes from the six-stage pipeline, in which the two multiplies
// of the premultiply and gain scaling each own a stage.
// Each stage has its own valid bit and moves when its successor has room, so
// a stalled receiver holds the result in the output register while the
// earlier stages keep filling their empty slots; nothing is lost or repeated.
// Synchronous reset clears all valid bits, sets the key mode to red and the
// gain to unity.
`timescale 1ns / 1ps
`default_nettype none

module rgb_color_difference_mask (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_in_alpha,
    input  wire logic [7:0]  i_in_red,
    input  wire logic [7:0]  i_in_green,
    input  wire logic [7:0]  i_in_blue,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_mask_alpha
);

    localparam int STAGES = rcdm_pkg::STAGES;

    logic [2:0]  r_key_mode;
    logic [15:0] r_gain;

    logic [STAGES:1]   r_vld;
    logic [STAGES:1]   stage_en;
    logic [STAGES-1:1] r_azero;

    logic                 invert;
    rcdm_pkg::t_lane_ctrl lane_ctrl;
    logic [7:0]           red_p;
    logic [7:0]           green_p;
    logic [7:0]           blue_p;

    logic [7:0]  key_val;
    logic [7:0]  r_key;
    logic [23:0] r_scaled;
    logic        r_sat;
    logic [30:0] r_quot;
    logic [7:0]  r_mask;

    // Difference of one channel against the larger of the other two, floored at 0.
    function automatic logic [7:0] diff_clamped(input logic [7:0] a, input logic [7:0] b,
                                                input logic [7:0] c);
        logic [7:0] m;
        m = (b > c) ? b : c;
        return (a > m) ? (a - m) : 8'd0;
    endfunction

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_mode <= rcdm_pkg::KEY_MODE_RESET;
            r_gain     <= rcdm_pkg::GAIN_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                rcdm_pkg::CFG_KEY_MODE: r_key_mode <= i_cfg_data[2:0];
                rcdm_pkg::CFG_GAIN:     r_gain     <= i_cfg_data;
                default:                r_gain     <= r_gain;
            endcase
        end
    end

    // Each stage may load when it is empty or its content moves on.
    always_comb begin
        stage_en[STAGES] = !r_vld[STAGES] || i_out_ready;
        for (int k = STAGES - 1; k >= 1; k--) begin
            stage_en[k] = !r_vld[k] || stage_en[k + 1];
        end
    end

    assign o_in_ready  = stage_en[1];
    assign o_out_valid = r_vld[STAGES];

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stage_en[1]) begin
                r_vld[1] <= i_in_valid;
            end
            for (int k = 2; k <= STAGES; k++) begin
                if (stage_en[k]) begin
                    r_vld[k] <= r_vld[k - 1];
                end
            end
        end
    end

    // The zero-alpha flag follows the pixel down to the output register.
    always_ff @(posedge i_clk) begin
        if (stage_en[1]) begin
            r_azero[1] <= (i_in_alpha == 8'd0);
        end
        for (int k = 2; k <= STAGES - 1; k++) begin
            if (stage_en[k]) begin
                r_azero[k] <= r_azero[k - 1];
            end
        end
    end

    // Channel lanes: stages one and two.
    assign invert = (r_key_mode == rcdm_pkg::MODE_CYAN) ||
                    (r_key_mode == rcdm_pkg::MODE_MAGENTA) ||
                    (r_key_mode == rcdm_pkg::MODE_YELLOW);

    assign lane_ctrl.en_mul = stage_en[1];
    assign lane_ctrl.en_div = stage_en[2];
    assign lane_ctrl.invert = invert;

    rcdm_lane u_lane_red (
        .i_clk   (i_clk),
        .i_ctrl  (lane_ctrl),
        .i_alpha (i_in_alpha),
        .i_chan  (i_in_red),
        .o_chan  (red_p)
    );

    rcdm_lane u_lane_green (
        .i_clk   (i_clk),
        .i_ctrl  (lane_ctrl),
        .i_alpha (i_in_alpha),
        .i_chan  (i_in_green),
        .o_chan  (green_p)
    );

    rcdm_lane u_lane_blue (
        .i_clk   (i_clk),
        .i_ctrl  (lane_ctrl),
        .i_alpha (i_in_alpha),
        .i_chan  (i_in_blue),
        .o_chan  (blue_p)
    );

    // Key value selection by mode.
    always_comb begin
        unique case (r_key_mode)
            rcdm_pkg::MODE_RED, rcdm_pkg::MODE_CYAN:
                key_val = diff_clamped(red_p, green_p, blue_p);
            rcdm_pkg::MODE_GREEN, rcdm_pkg::MODE_MAGENTA:
                key_val = diff_clamped(green_p, blue_p, red_p);
            rcdm_pkg::MODE_BLUE, rcdm_pkg::MODE_YELLOW:
                key_val = diff_clamped(blue_p, red_p, green_p);
            rcdm_pkg::MODE_MAX: begin
                key_val = (red_p > green_p) ? red_p : green_p;
                key_val = (blue_p > key_val) ? blue_p : key_val;
            end
            rcdm_pkg::MODE_UNUSED:
                key_val = 8'd0;
            default:
                key_val = 8'd0;
        endcase
    end

    // Stage three: key value.
    always_ff @(posedge i_clk) begin
        if (stage_en[3]) begin
            r_key <= key_val;
        end
    end

    // Stage four: key times gain plus half of one thousand.
    always_ff @(posedge i_clk) begin
        if (stage_en[4]) begin
            r_scaled <= ({16'd0, r_key} * {8'd0, r_gain}) + rcdm_pkg::GAIN_ROUND;
        end
    end

    // Stage five: saturation test and reciprocal multiply of the value / 8 by 125.
    always_ff @(posedge i_clk) begin
        if (stage_en[5]) begin
            r_sat  <= (r_scaled >= rcdm_pkg::SAT_LIMIT);
            r_quot <= {16'd0, r_scaled[17:3]} * {15'd0, rcdm_pkg::RECIP_125};
        end
    end

    // Stage six: output register.
    always_ff @(posedge i_clk) begin
        if (stage_en[6]) begin
            if (r_azero[5]) begin
                r_mask <= 8'd0;
            end else if (r_sat) begin
                r_mask <= rcdm_pkg::CHAN_MAX;
            end else begin
                r_mask <= r_quot[rcdm_pkg::RECIP_SHIFT + 7:rcdm_pkg::RECIP_SHIFT];
            end
        end
    end

    assign o_mask_alpha = r_mask;

endmodule

`default_nettype wire

// File: hw/rtl/rcdm_checker.sv
// Port-level checker for the color difference mask, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "rgb_color_difference_mask_macros.svh"

module rcdm_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_in_ready,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] o_mask_alpha
);

    logic out_stall;

    // A result is offered and the receiver holds it off.
    assign out_stall = o_out_valid && !i_out_ready;

    // A result waiting on a stalled receiver stays offered.
    `RCDM_ASSERT_NXT(a_out_valid_held, i_clk, i_rst_n, out_stall, o_out_valid)

    // A stalled result keeps its value.
    `RCDM_ASSERT_NXT(a_out_data_held, i_clk, i_rst_n, out_stall, $stable(o_mask_alpha))

    // Reset empties the pipeline.
    `RCDM_ASSERT_NXT_ALWAYS(a_reset_empties, i_clk, !i_rst_n, !o_out_valid)

    // With the output register empty the whole pipeline has room for a request.
    `RCDM_ASSERT_IMP(a_ready_when_drained, i_clk, i_rst_n, !o_out_valid, o_in_ready)

    // A receiver that takes results lets every stage move, so input is ready.
    `RCDM_ASSERT_IMP(a_ready_follows_receiver, i_clk, i_rst_n, i_out_ready, o_in_ready)

endmodule

bind rgb_color_difference_mask rcdm_checker u_rcdm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_mask_alpha (o_mask_alpha)
);

`default_nettype wire

// File: dv/rgb_color_difference_mask_tb.sv
// Self-checking testbench for the color difference key mask pipeline.
`timescale 1ns / 1ps

module rgb_color_difference_mask_tb;

    localparam int PHASES          = 12;
    localparam int PHASE_ITEMS     = 100;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int UNITY_GAIN      = 1000;
    localparam int PREDICTED       = -1;
    localparam int DIRECTED_ROWS   = 25;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    // One directed request: the settings it runs under, the pixel, and the
    // mask typed in by hand, or PREDICTED to take it from the predictor.
    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] gain;
        logic [7:0]  alpha;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        int          want;
    } t_directed_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic        i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_in_alpha;
    logic [7:0]  i_in_red;
    logic [7:0]  i_in_green;
    logic [7:0]  i_in_blue;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [7:0]  o_mask_alpha;

    // Masks still owed by the block, oldest first.
    logic [7:0]  mask_expected [$];
    logic [2:0]  key_mode_shadow = rcdm_pkg::KEY_MODE_RESET;
    logic [15:0] gain_shadow     = rcdm_pkg::GAIN_RESET;
    logic        valid_offered   = 1'b0;
    bit          idle_on         = 1'b1;
    bit          hold_off_req    = 1'b0;
    int          mismatch_count  = 0;

    t_directed_row directed_rows [DIRECTED_ROWS] = '{
        // Primary modes at unity gain, starting with the reset settings: red keyed.
        '{rcdm_pkg::MODE_RED,     16'd1000,  8'd255, 8'd255, 8'd0,   8'd0,   255},
        '{rcdm_pkg::MODE_RED,     16'd1000,  8'd0,   8'd255, 8'd0,   8'd0,   0},
        '{rcdm_pkg::MODE_RED,     16'd1000,  8'd255, 8'd255, 8'd255, 8'd255, 0},
        '{rcdm_pkg::MODE_RED,     16'd1000,  8'd255, 8'd200, 8'd50,  8'd100, 100},
        '{rcdm_pkg::MODE_RED,     16'd1000,  8'd255, 8'd0,   8'd255, 8'd255, 0},
        '{rcdm_pkg::MODE_GREEN,   16'd1000,  8'd255, 8'd10,  8'd250, 8'd20,  230},
        '{rcdm_pkg::MODE_BLUE,    16'd1000,  8'd255, 8'd0,   8'd0,   8'd255, 255},
        // Inverted modes, where the complementary primary gives a full mask, then max mode.
        '{rcdm_pkg::MODE_CYAN,    16'd1000,  8'd255, 8'd0,   8'd255, 8'd255, 255},
        '{rcdm_pkg::MODE_MAGENTA, 16'd1000,  8'd255, 8'd255, 8'd0,   8'd255, 255},
        '{rcdm_pkg::MODE_YELLOW,  16'd1000,  8'd255, 8'd255, 8'd255, 8'd0,   255},
        '{rcdm_pkg::MODE_CYAN,    16'd1000,  8'd255, 8'd255, 8'd255, 8'd255, 0},
        '{rcdm_pkg::MODE_MAX,     16'd1000,  8'd255, 8'd1,   8'd2,   8'd200, 200},
        // Partial alpha goes through the premultiply.
        '{rcdm_pkg::MODE_MAX,     16'd1000,  8'd128, 8'd255, 8'd0,   8'd0,   PREDICTED},
        '{rcdm_pkg::MODE_MAX,     16'd1000,  8'd1,   8'd255, 8'd255, 8'd255, PREDICTED},
        '{rcdm_pkg::MODE_MAX,     16'd1000,  8'd254, 8'd255, 8'd255, 8'd255, PREDICTED},
        '{rcdm_pkg::MODE_YELLOW,  16'd1000,  8'd100, 8'd30,  8'd60,  8'd200, PREDICTED},
        // The unused mode never keys anything.
        '{rcdm_pkg::MODE_UNUSED,  16'd1000,  8'd255, 8'd255, 8'd255, 8'd255, 0},
        '{rcdm_pkg::MODE_UNUSED,  16'd1000,  8'd0,   8'd0,   8'd0,   8'd0,   0},
        // Gain extremes, saturation and rounding of halves.
        '{rcdm_pkg::MODE_MAX,     16'd0,     8'd255, 8'd255, 8'd255, 8'd255, 0},
        '{rcdm_pkg::MODE_MAX,     16'd65535, 8'd255, 8'd1,   8'd0,   8'd0,   PREDICTED},
        '{rcdm_pkg::MODE_MAX,     16'd65535, 8'd255, 8'd255, 8'd255, 8'd255, 255},
        '{rcdm_pkg::MODE_MAX,     16'd50000, 8'd255, 8'd5,   8'd0,   8'd0,   250},
        '{rcdm_pkg::MODE_MAX,     16'd50000, 8'd255, 8'd6,   8'd0,   8'd0,   255},
        '{rcdm_pkg::MODE_MAX,     16'd50000, 8'd0,   8'd255, 8'd255, 8'd255, 0},
        '{rcdm_pkg::MODE_MAX,     16'd500,   8'd255, 8'd1,   8'd0,   8'd0,   PREDICTED}
    };

    rgb_color_difference_mask dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_alpha   (i_in_alpha),
        .i_in_red     (i_in_red),
        .i_in_green   (i_in_green),
        .i_in_blue    (i_in_blue),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_mask_alpha (o_mask_alpha)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Key channel minus the brighter of the other two, floored at zero.
    function automatic int unsigned key_excess(int unsigned keyed, int unsigned other_a,
                                               int unsigned other_b);
        int unsigned brightest;
        brightest = (other_a > other_b) ? other_a : other_b;
        return (keyed > brightest) ? keyed - brightest : 0;
    endfunction

    // Mask alpha that the block should give for one pixel under given settings.
    function automatic logic [7:0] predict_mask(logic [2:0] mode, logic [15:0] gain,
                                                t_pixel px);
        int unsigned a;
        int unsigned r;
        int unsigned g;
        int unsigned b;
        int unsigned keyed;
        int unsigned scaled;
        a = 32'(px.alpha);
        r = 32'(px.red);
        g = 32'(px.green);
        b = 32'(px.blue);
        keyed = 0;
        if (a == 0) begin
            return 8'd0;
        end
        if (mode == rcdm_pkg::MODE_CYAN || mode == rcdm_pkg::MODE_MAGENTA ||
            mode == rcdm_pkg::MODE_YELLOW) begin
            r = rcdm_pkg::CHAN_MAX - r;
            g = rcdm_pkg::CHAN_MAX - g;
            b = rcdm_pkg::CHAN_MAX - b;
        end
        if (a < rcdm_pkg::CHAN_MAX) begin
            r = (r * a + 127) / rcdm_pkg::CHAN_MAX;
            g = (g * a + 127) / rcdm_pkg::CHAN_MAX;
            b = (b * a + 127) / rcdm_pkg::CHAN_MAX;
        end
        case (mode)
            rcdm_pkg::MODE_RED, rcdm_pkg::MODE_CYAN:      keyed = key_excess(r, g, b);
            rcdm_pkg::MODE_GREEN, rcdm_pkg::MODE_MAGENTA: keyed = key_excess(g, b, r);
            rcdm_pkg::MODE_BLUE, rcdm_pkg::MODE_YELLOW:   keyed = key_excess(b, r, g);
            rcdm_pkg::MODE_MAX: begin
                keyed = (r > g) ? r : g;
                keyed = (keyed > b) ? keyed : b;
            end
            default:                                      keyed = 0;
        endcase
        scaled = (keyed * gain + UNITY_GAIN / 2) / UNITY_GAIN;
        if (scaled > rcdm_pkg::CHAN_MAX) begin
            scaled = rcdm_pkg::CHAN_MAX;
        end
        return scaled[7:0];
    endfunction

    // Channel values lean toward the extremes so clamping shows up often.
    function automatic logic [7:0] pick_channel();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'd65535;
            2:       return 16'd50000;
            3:       return 16'(UNITY_GAIN);
            4:       return 16'($urandom_range(1, 2000));
            7:       return 16'($urandom_range(50001, 65535));
            default: return 16'($urandom_range(0, 50000));
        endcase
    endfunction

    function automatic t_pixel random_pixel();
        t_pixel px;
        case ($urandom_range(0, 7))
            0:       px.alpha = 8'd0;
            1, 2:    px.alpha = 8'd255;
            default: px.alpha = 8'($urandom_range(0, 255));
        endcase
        px.red   = pick_channel();
        px.green = pick_channel();
        px.blue  = pick_channel();
        return px;
    endfunction

    // Valid gets at most one assignment per time step.
    task automatic set_in_valid(input logic level);
        if (level !== valid_offered) begin
            i_in_valid <= level;
            valid_offered = level;
        end
    endtask

    // Offer one pixel, with an optional idle burst first, and record its mask
    // once the request is taken. Valid stays high on return.
    task automatic send_pixel(input t_pixel px, input int want);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 14);
            set_in_valid(1'b0);
            repeat (gap) @(posedge i_clk);
        end
        i_in_alpha <= px.alpha;
        i_in_red   <= px.red;
        i_in_green <= px.green;
        i_in_blue  <= px.blue;
        set_in_valid(1'b1);
        do @(posedge i_clk); while (!o_in_ready);
        if (want == PREDICTED) begin
            mask_expected.push_back(predict_mask(key_mode_shadow, gain_shadow, px));
        end else begin
            mask_expected.push_back(want[7:0]);
        end
    endtask

    // Stop offering and wait until every owed mask has come out.
    task automatic drain_pipeline();
        set_in_valid(1'b0);
        while (mask_expected.size() != 0) @(posedge i_clk);
    endtask

    // Write both registers on back-to-back edges; only called while idle.
    task automatic configure(input logic [2:0] mode, input logic [15:0] gain);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= rcdm_pkg::CFG_KEY_MODE;
        i_cfg_data  <= {13'd0, mode};
        @(posedge i_clk);
        i_cfg_index <= rcdm_pkg::CFG_GAIN;
        i_cfg_data  <= gain;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        key_mode_shadow = mode;
        gain_shadow     = gain;
    endtask

    task automatic check_mask(input logic [7:0] got);
        logic [7:0] want;
        if (mask_expected.size() == 0) begin
            if (mismatch_count < 10) begin
                $display("unexpected mask result: mask_alpha %0d", got);
            end
            mismatch_count++;
        end else begin
            want = mask_expected.pop_front();
            if (got !== want) begin
                if (mismatch_count < 10) begin
                    $display("mask_alpha mismatch: expected %0d, actual %0d", want, got);
                end
                mismatch_count++;
            end
        end
    endtask

    // Result side: checks each taken mask and drives ready, with random
    // stalls and one long hold-off when the stimulus asks for it.
    initial begin : result_side
        int stall_left;
        stall_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                check_mask(o_mask_alpha);
            end
            if (hold_off_req) begin
                stall_left   = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end else if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 14);
            end
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Stimulus: reset, directed table, then random phases under fresh settings.
    initial begin : stimulus
        t_pixel      px;
        logic [2:0]  mode;
        logic [15:0] gain;
        i_rst_n     <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_index <= rcdm_pkg::CFG_KEY_MODE;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_in_alpha  <= '0;
        i_in_red    <= '0;
        i_in_green  <= '0;
        i_in_blue   <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            if (directed_rows[k].mode != key_mode_shadow ||
                directed_rows[k].gain != gain_shadow) begin
                drain_pipeline();
                configure(directed_rows[k].mode, directed_rows[k].gain);
            end
            px = {directed_rows[k].alpha, directed_rows[k].red,
                  directed_rows[k].green, directed_rows[k].blue};
            send_pixel(px, directed_rows[k].want);
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            drain_pipeline();
            // Early phases step through every mode and the gain extremes.
            mode = (phase < 8) ? 3'(phase) : 3'($urandom_range(0, 7));
            case (phase)
                0:       gain = 16'd65535;
                1:       gain = 16'd0;
                2:       gain = 16'd50000;
                3:       gain = 16'(UNITY_GAIN);
                default: gain = pick_gain();
            endcase
            configure(mode, gain);
            idle_on = (phase == PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
            // A long receiver hold-off lets the pipeline fill and stall input.
            if (phase == 5) begin
                idle_on      = 1'b0;
                hold_off_req = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // The sender pauses once until the pipeline is empty.
                if (phase == 8 && n == PHASE_ITEMS / 2) begin
                    drain_pipeline();
                end
                send_pixel(random_pixel(), PREDICTED);
            end
        end

        drain_pipeline();
        repeat (2 * rcdm_pkg::STAGES) @(posedge i_clk);
        if (mask_expected.size() != 0) begin
            $display("%0d expected masks never arrived", mask_expected.size());
            mismatch_count += mask_expected.size();
        end
        if (mismatch_count == 0) begin
            $display("rgb_color_difference_mask_tb passed");
        end else begin
            $display("rgb_color_difference_mask_tb failed");
        end
        $finish;
    end

    // Hang guard, far beyond the slowest correct run.
    initial begin : watchdog
        #5000000;
        $display("rgb_color_difference_mask_tb failed");
        $finish;
    end

endmodule
